### design/rlg_pkg.sv
// Package with shared types, constants and the glyph ROM of the span rasteriser.
`timescale 1ns / 1ps
`default_nettype none
package rlg_pkg;

  localparam int unsigned MaxHeight = 32;
  localparam int unsigned MaxWidth  = 128;
  localparam int unsigned GlyphRows = 7;
  localparam int unsigned RomSize   = 31;
  localparam int unsigned RomDepth  = 32;
  localparam int unsigned RomAddrW  = $clog2(RomDepth * 8);

  typedef enum logic [2:0] {
    MODE_FILL    = 3'd0,
    MODE_OUTLINE = 3'd1,
    MODE_HLINE   = 3'd2,
    MODE_VLINE   = 3'd3,
    MODE_GLYPH   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHAPE,
    ST_GREQ,
    ST_GROW,
    ST_GSCAN
  } state_e;

  // Code bytes of the glyph set, in ROM order.
  function automatic logic [7:0] rom_code(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx)
      5'd0: c = 8'h20;  5'd1: c = 8'h2D;  5'd2: c = 8'h21;
      5'd3: c = 8'h30;  5'd4: c = 8'h31;  5'd5: c = 8'h32;
      5'd6: c = 8'h33;  5'd7: c = 8'h34;  5'd8: c = 8'h35;
      5'd9: c = 8'h36;  5'd10: c = 8'h37; 5'd11: c = 8'h38;
      5'd12: c = 8'h39; 5'd13: c = 8'h41; 5'd14: c = 8'h43;
      5'd15: c = 8'h44; 5'd16: c = 8'h45; 5'd17: c = 8'h47;
      5'd18: c = 8'h48; 5'd19: c = 8'h49; 5'd20: c = 8'h4C;
      5'd21: c = 8'h4D; 5'd22: c = 8'h4E; 5'd23: c = 8'h4F;
      5'd24: c = 8'h50; 5'd25: c = 8'h52; 5'd26: c = 8'h53;
      5'd27: c = 8'h54; 5'd28: c = 8'h55; 5'd29: c = 8'h56;
      5'd30: c = 8'h59;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Packed glyph rows, row 0 in the low five bits; bit 4 is the leftmost column.
  function automatic logic [34:0] rom_glyph(input logic [4:0] idx);
    logic [34:0] g;
    unique case (idx)
      5'd0:  g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00};
      5'd1:  g = {5'h00,5'h00,5'h00,5'h0E,5'h00,5'h00,5'h00};
      5'd2:  g = {5'h04,5'h00,5'h04,5'h04,5'h04,5'h04,5'h04};
      5'd3:  g = {5'h0E,5'h11,5'h19,5'h15,5'h13,5'h11,5'h0E};
      5'd4:  g = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h0C,5'h04};
      5'd5:  g = {5'h1F,5'h08,5'h04,5'h02,5'h01,5'h11,5'h0E};
      5'd6:  g = {5'h0E,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0E};
      5'd7:  g = {5'h02,5'h02,5'h1F,5'h12,5'h0A,5'h06,5'h02};
      5'd8:  g = {5'h0E,5'h11,5'h01,5'h01,5'h1E,5'h10,5'h1F};
      5'd9:  g = {5'h0E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h0E};
      5'd10: g = {5'h08,5'h08,5'h08,5'h04,5'h02,5'h01,5'h1F};
      5'd11: g = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
      5'd12: g = {5'h0E,5'h01,5'h01,5'h0F,5'h11,5'h11,5'h0E};
      5'd13: g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h0E};
      5'd14: g = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
      5'd15: g = {5'h1C,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1C};
      5'd16: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
      5'd17: g = {5'h0E,5'h11,5'h11,5'h17,5'h10,5'h11,5'h0E};
      5'd18: g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
      5'd19: g = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
      5'd20: g = {5'h1F,5'h10,5'h10,5'h10,5'h10,5'h10,5'h10};
      5'd21: g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11};
      5'd22: g = {5'h11,5'h11,5'h13,5'h15,5'h15,5'h19,5'h11};
      5'd23: g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
      5'd24: g = {5'h10,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h1E};
      5'd25: g = {5'h11,5'h12,5'h14,5'h1E,5'h11,5'h11,5'h1E};
      5'd26: g = {5'h1E,5'h01,5'h01,5'h0E,5'h10,5'h10,5'h0F};
      5'd27: g = {5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F};
      5'd28: g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h11};
      5'd29: g = {5'h04,5'h0A,5'h11,5'h11,5'h11,5'h11,5'h11};
      5'd30: g = {5'h04,5'h04,5'h04,5'h04,5'h0A,5'h11,5'h11};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

### design/rlg_rom.sv
// Glyph ROM: one row of five pixels per word, registered read.
`timescale 1ns / 1ps
`default_nettype none
module rlg_rom (
  input  wire logic                         clk_i,
  input  wire logic [rlg_pkg::RomAddrW-1:0] addr_i,
  output logic      [4:0]                   data_o
);

  localparam int unsigned RomAddrLocal = rlg_pkg::RomAddrW;

  logic [4:0] data_q;

  // Address is {glyph index, row}; rows beyond the glyph read as blank.
  always_ff @(posedge clk_i) begin
    logic [34:0] g;
    g = rlg_pkg::rom_glyph(addr_i[RomAddrLocal-1:3]);
    if (addr_i[2:0] < 3'd7) begin
      data_q <= g[5*addr_i[2:0] +: 5];
    end else begin
      data_q <= '0;
    end
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

### design/rect_line_glyph_span_rasterizer_core.sv
// Top level of the rectangle, line and glyph span rasteriser.
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Direction | Handshake           | Payload
// command   | in        | start_i / busy_o    | mode, x, y, width, height, char_code, color
// run       | out       | run_valid_o strobe  | row, start_col, run_length, pixel_color, last
//
// One run leaves per cycle for rectangles and lines; a 32-row outline wider than two
// pixels makes 62 runs. A glyph reads the glyph ROM one row at a time: each row passes
// the request and row states for the registered ROM port, then the scan state steps
// over each blank column ahead of a run and emits each run, or ends an empty row at
// once; the held run then drains after the last row.
// Reset clears the control state only. The receiver cannot stall; busy_o holds
// off new commands until the last run has left.
module rect_line_glyph_span_rasterizer_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [2:0] mode_i,
  input  wire logic signed [7:0] x_i,
  input  wire logic signed [6:0] y_i,
  input  wire logic [7:0] width_i,
  input  wire logic [5:0] height_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic [7:0] color_i,
  output logic            run_valid_o,
  output logic signed [7:0] row_o,
  output logic signed [8:0] start_col_o,
  output logic [7:0]      run_length_o,
  output logic [7:0]      pixel_color_o,
  output logic            last_o
);

  rlg_pkg::state_e state_q, state_d;
  logic [2:0]  mode_q;
  logic signed [7:0] x_q;
  logic signed [6:0] y_q;
  logic [7:0]  w_q;
  logic [5:0]  h_q;
  logic [7:0]  color_q;
  logic [4:0]  gidx_q;
  logic [5:0]  j_q, j_d;
  logic        side_q, side_d;
  logic [4:0]  bits_q, bits_d;
  logic [2:0]  col_q, col_d;
  logic [4:0]  rom_data;

  // Emission register.
  logic        ov_q, ov_d, last_q, last_d;
  logic signed [7:0] row_q, row_d;
  logic signed [8:0] scol_q, scol_d;
  logic [7:0]  len_q, len_d;

  // Command decode and glyph lookup.
  logic [7:0]  w_sat;
  logic [5:0]  h_sat;
  logic [7:0]  code_f;
  logic        g_hit;
  logic [4:0]  g_idx;
  logic        accept;

  assign accept = start_i && !busy_o;
  assign w_sat  = (width_i > 8'(rlg_pkg::MaxWidth)) ? 8'(rlg_pkg::MaxWidth) : width_i;
  assign h_sat  = (height_i > 6'(rlg_pkg::MaxHeight)) ? 6'(rlg_pkg::MaxHeight) : height_i;

  always_comb begin
    code_f = char_code_i;
    if (char_code_i >= 8'h61 && char_code_i <= 8'h7A) begin
      code_f = char_code_i - 8'h20;
    end
    g_hit = 1'b0;
    g_idx = '0;
    for (int i = 0; i < rlg_pkg::RomSize; i++) begin
      if (rlg_pkg::rom_code(5'(i)) == code_f) begin
        g_hit = 1'b1;
        g_idx = 5'(i);
      end
    end
  end

  rlg_rom u_rom (
    .clk_i  (clk_i),
    .addr_i ({gidx_q, j_q[2:0]}),
    .data_o (rom_data)
  );

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rlg_pkg::ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // Command and run registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      x_q     <= x_i;
      y_q     <= y_i;
      w_q     <= w_sat;
      h_q     <= h_sat;
      color_q <= color_i;
      gidx_q  <= g_idx;
    end
    j_q    <= j_d;
    side_q <= side_d;
    bits_q <= bits_d;
    col_q  <= col_d;
    row_q  <= row_d;
    scol_q <= scol_d;
    len_q  <= len_d;
    last_q <= last_d;
  end

  // Next state and run generation.
  always_comb begin
    logic [5:0] hm1;
    logic [2:0] e;
    logic       more;
    state_d = state_q;
    j_d = j_q; side_d = side_q; bits_d = bits_q; col_d = col_q;
    ov_d = 1'b0; row_d = row_q; scol_d = scol_q; len_d = len_q; last_d = 1'b0;
    hm1 = h_q - 6'd1;
    e = col_q;
    more = 1'b0;
    unique case (state_q)
      rlg_pkg::ST_IDLE: begin
        j_d = '0; side_d = 1'b0;
        if (accept) begin
          unique case (mode_i)
            rlg_pkg::MODE_FILL, rlg_pkg::MODE_OUTLINE:
              state_d = (w_sat != 0 && h_sat != 0) ? rlg_pkg::ST_SHAPE : rlg_pkg::ST_IDLE;
            rlg_pkg::MODE_HLINE:
              state_d = (w_sat != 0) ? rlg_pkg::ST_SHAPE : rlg_pkg::ST_IDLE;
            rlg_pkg::MODE_VLINE:
              state_d = (h_sat != 0) ? rlg_pkg::ST_SHAPE : rlg_pkg::ST_IDLE;
            rlg_pkg::MODE_GLYPH:
              state_d = g_hit ? rlg_pkg::ST_GREQ : rlg_pkg::ST_IDLE;
            default: state_d = rlg_pkg::ST_IDLE;
          endcase
        end
      end
      rlg_pkg::ST_SHAPE: begin
        ov_d  = 1'b1;
        row_d = 8'(y_q) + 8'(j_q);
        scol_d = 9'(x_q);
        len_d = w_q;
        j_d = j_q + 6'd1;
        unique case (mode_q)
          rlg_pkg::MODE_HLINE: last_d = 1'b1;
          rlg_pkg::MODE_VLINE: begin
            len_d = 8'd1;
            last_d = (j_q == hm1);
          end
          rlg_pkg::MODE_OUTLINE: begin
            last_d = (j_q == hm1);
            if (j_q != 0 && j_q != hm1 && w_q > 8'd2) begin
              len_d = 8'd1;
              if (side_q) begin
                scol_d = 9'(x_q) + 9'(w_q) - 9'd1;
                side_d = 1'b0;
              end else begin
                side_d = 1'b0 | 1'b1;
                j_d = j_q;
              end
            end
          end
          default: last_d = (j_q == hm1);
        endcase
        if (last_d) state_d = rlg_pkg::ST_IDLE;
      end
      rlg_pkg::ST_GREQ: begin
        // ROM address for row j_q is presented this cycle.
        state_d = rlg_pkg::ST_GROW;
      end
      rlg_pkg::ST_GROW: begin
        bits_d = rom_data;
        col_d = '0;
        state_d = rlg_pkg::ST_GSCAN;
      end
      rlg_pkg::ST_GSCAN: begin
        // Find the next run within the row from col_q.
        priority if (col_q > 3'd4 || (bits_q & (5'h1F >> col_q)) == 0) begin
          e = 3'd5;
        end else if (!bits_q[3'd4 - col_q]) begin
          col_d = col_q + 3'd1;
          e = col_q;
        end else begin
          e = col_q;
          for (int k = 0; k < 5; k++) begin
            if (32'(e) == k && e < 3'd5 && bits_q[3'd4 - e]) e = e + 3'd1;
          end
          ov_d = 1'b1;
          row_d = 8'(y_q) + 8'(j_q);
          scol_d = 9'(x_q) + 9'(col_q);
          len_d = 8'(e - col_q);
          col_d = e;
          more = (e < 3'd5) && ((bits_q & (5'h1F >> e)) != 0);
        end
        if (e == 3'd5 || (ov_d && !more)) begin
          // Row finished: on the last glyph row, the run emitted here, if any, is the last.
          if (j_q == 6'd6) begin
            last_d = ov_d;
            state_d = rlg_pkg::ST_IDLE;
          end else begin
            j_d = j_q + 6'd1;
            state_d = rlg_pkg::ST_GREQ;
          end
        end
      end
      default: state_d = rlg_pkg::ST_IDLE;
    endcase
  end

  // Runs are held back one run so the final one can carry the last flag.
  logic        hv_q;
  logic signed [7:0] hrow_q;
  logic signed [8:0] hcol_q;
  logic [7:0]  hlen_q;
  logic [7:0]  hcolor_q;
  logic        hlast_q;
  logic        cmd_end;

  // The glyph's command ends when the scanner returns to idle.
  assign cmd_end = (state_q == rlg_pkg::ST_IDLE) && (mode_q == rlg_pkg::MODE_GLYPH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= 1'b0;
    end else if (ov_q) begin
      hv_q <= 1'b1;
    end else if (hv_q && (hlast_q || cmd_end)) begin
      hv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ov_q) begin
      hrow_q <= row_q; hcol_q <= scol_q; hlen_q <= len_q;
      hcolor_q <= color_q; hlast_q <= last_q;
    end
  end

  assign run_valid_o   = hv_q && (ov_q || hlast_q || cmd_end);
  assign row_o         = hrow_q;
  assign start_col_o   = hcol_q;
  assign run_length_o  = hlen_q;
  assign pixel_color_o = hcolor_q;
  assign last_o        = hlast_q || (!ov_q && cmd_end);
  assign busy_o        = (state_q != rlg_pkg::ST_IDLE) || ov_q || hv_q;

  // A run never leaves with zero length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_o |-> run_length_o != 8'd0) else $error("zero-length run");
  // No command is taken while runs are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hv_q |-> busy_o) else $error("accept while runs pending");
  // After the last run the block drains to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_valid_o && last_o) |=> !hv_q) else $error("runs after last");

endmodule
`default_nettype wire
